/* rtl/spa_pkg.sv */
package spa_pkg;

  localparam int IDX_W = 3;
  localparam int VAL_W = 32;
  localparam int DEV_W = 33;
  localparam int PI_W  = 63;
  localparam int CNT_W = 32;
  localparam int NV_W  = 4;

  localparam logic [1:0] OP_LOAD_MEAN = 2'd0;
  localparam logic [1:0] OP_LOAD_COV  = 2'd1;
  localparam logic [1:0] OP_SAMPLE    = 2'd2;
  localparam logic [1:0] OP_FINISH    = 2'd3;

  localparam logic [PI_W-1:0]  PI_MAX    = {PI_W{1'b1}};
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic [1:0]       operation;
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
    logic [VAL_W-1:0] value;
  } spa_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] out_row;
    logic [IDX_W-1:0] out_col;
    logic [PI_W-1:0]  pi_value;
    logic             last_entry;
  } spa_out_t;

  // deviation travelling round the ring with its column index
  typedef struct packed {
    logic [DEV_W-1:0] d;
    logic [IDX_W-1:0] j;
  } spa_mv_t;

  typedef struct packed {
    logic             active;
    logic             mean_we;
    logic             cov_we;
    logic             dev_we;
    logic             mv_load;
    logic             mv_shift;
    logic             clr;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] rd_col;
    logic [VAL_W-1:0] value;
  } spa_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } spa_div_st_t;

endpackage

/* rtl/spa_cell.sv */
module spa_cell import spa_pkg::*; #(
  parameter int MAX_VARS = 8,
  parameter int CELL_IDX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  spa_ctl_t        ctl,
  input  spa_mv_t         nb_in,
  output spa_mv_t         mv_out,
  output logic [PI_W-1:0] rd_acc
);

  localparam int AW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;

  logic [VAL_W-1:0] mean_r;
  logic [DEV_W-1:0] dev_r;
  logic [VAL_W-1:0] cov_r [MAX_VARS];
  logic [PI_W-1:0]  acc_r [MAX_VARS];
  spa_mv_t          mv_r;

  logic [DEV_W-1:0] mi, mj;
  logic [63:0]      pm1_r;
  logic             neg1_r;
  logic [VAL_W-1:0] s1_r;
  logic [IDX_W-1:0] j1_r, j2_r, j3_r, j4_r;
  logic             v1_r, v2_r, v3_r, v4_r;

  logic [64:0]      rnd;
  logic [48:0]      qm;
  logic [49:0]      q, e, ea;
  logic [48:0]      em2_r;
  logic [33:0]      hh3_r;
  logic [48:0]      hl3_r;
  logic [63:0]      ll3_r;
  logic [97:0]      full;
  logic [PI_W-1:0]  t4_r;
  logic [63:0]      sum;

  assign mv_out = mv_r;
  assign rd_acc = acc_r[ctl.rd_col[AW-1:0]];

  always_ff @(posedge clk) begin
    if (ctl.mean_we) begin
      mean_r <= ctl.value;
    end
    if (ctl.dev_we) begin
      dev_r <= {ctl.value[VAL_W-1], ctl.value} - {mean_r[VAL_W-1], mean_r};
    end
    if (ctl.cov_we) begin
      cov_r[ctl.col[AW-1:0]] <= ctl.value;
    end
    if (ctl.mv_load) begin
      mv_r.d <= dev_r;
      mv_r.j <= IDX_W'(CELL_IDX);
    end else if (ctl.mv_shift) begin
      mv_r <= nb_in;
    end
  end

  // stage 1: magnitude product of the two deviations
  assign mi = dev_r[DEV_W-1] ? (~dev_r + 1'b1) : dev_r;
  assign mj = mv_r.d[DEV_W-1] ? (~mv_r.d + 1'b1) : mv_r.d;

  // stage 2: back to Q16.16 (floor) and take |q - s|
  assign rnd = {1'b0, pm1_r} + 65'h0FFFF;
  assign qm  = neg1_r ? rnd[64:16] : {1'b0, pm1_r[63:16]};
  assign q   = neg1_r ? (~{1'b0, qm} + 1'b1) : {1'b0, qm};
  assign e   = q - {{18{s1_r[VAL_W-1]}}, s1_r};
  assign ea  = e[49] ? (~e + 1'b1) : e;

  // stage 4: recombine the square from its partial products
  assign full = {hh3_r, 64'b0} + {16'b0, hl3_r, 33'b0} + {34'b0, ll3_r};
  assign sum  = {1'b0, acc_r[j4_r[AW-1:0]]} + {1'b0, t4_r};

  always_ff @(posedge clk) begin
    pm1_r  <= 64'(mi[31:0]) * 64'(mj[31:0]);
    neg1_r <= dev_r[DEV_W-1] ^ mv_r.d[DEV_W-1];
    s1_r   <= cov_r[mv_r.j[AW-1:0]];
    j1_r   <= mv_r.j;
    em2_r  <= ea[48:0];
    j2_r   <= j1_r;
    hh3_r  <= 34'(em2_r[48:32]) * 34'(em2_r[48:32]);
    hl3_r  <= 49'(em2_r[48:32]) * 49'(em2_r[31:0]);
    ll3_r  <= 64'(em2_r[31:0]) * 64'(em2_r[31:0]);
    j3_r   <= j2_r;
    t4_r   <= (|full[97:79]) ? PI_MAX : full[78:16];
    j4_r   <= j3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= ctl.mv_shift & ctl.active;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      for (int k = 0; k < MAX_VARS; k++) begin
        acc_r[k] <= '0;
      end
    end else if (v4_r) begin
      acc_r[j4_r[AW-1:0]] <= sum[63] ? PI_MAX : sum[PI_W-1:0];
    end
  end

endmodule

/* rtl/spa_div.sv */
module spa_div import spa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [PI_W-1:0]  dividend,
  input  logic [CNT_W-1:0] divisor,
  output spa_div_st_t      status,
  output logic [PI_W-1:0]  quotient
);

  logic [PI_W-1:0]  quo_r;
  logic [CNT_W-1:0] rem_r;
  logic [5:0]       cnt_r;
  logic             busy_r, done_r;
  logic [CNT_W:0]   sh, diff;

  assign sh       = {rem_r, quo_r[PI_W-1]};
  assign diff     = sh - {1'b0, divisor};
  assign status   = '{busy: busy_r, done: done_r};
  assign quotient = (divisor == '0) ? '0 : quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(PI_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      if (!diff[CNT_W]) begin
        rem_r <= diff[CNT_W-1:0];
        quo_r <= {quo_r[PI_W-2:0], 1'b1};
      end else begin
        rem_r <= sh[CNT_W-1:0];
        quo_r <= {quo_r[PI_W-2:0], 1'b0};
      end
    end
  end

endmodule

/* rtl/shrinkage_pi_accumulator.sv */
// Ledoit-Wolf Pi estimate in Q47.16 from Q16.16 inputs. Each of the MAX_VARS cells holds one
// variable's mean, deviation, covariance row and Pi accumulator row. Mean, covariance and
// ordinary sample transactions are taken without leaving the idle state. The sample that closes
// a column loads the deviations into the ring, rotates them round the active cells, each cell
// feeding its own four-stage multiply pipeline, then the pipeline drains into the accumulators.
// A finish transaction emits n*n entries (n = active variables), each divided by the sample
// count in the bit-serial divider and held until the receiver takes it.
module shrinkage_pi_accumulator import spa_pkg::*; #(
  parameter int MAX_VARS = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  spa_in_t         in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output spa_out_t        out_data,
  input  logic            cfg_we,
  input  logic [NV_W-1:0] cfg_data
);

  localparam int AW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_SWEEP  = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_DSTART = 3'd4;
  localparam logic [2:0] S_DWAIT  = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [NV_W-1:0]  nv_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NV_W-1:0]  sc_r;
  logic [2:0]       dc_r;
  logic [IDX_W-1:0] ei_r, ej_r;
  logic             out_valid_r;
  spa_out_t         out_r;
  logic             acc_clr;

  logic             accept;
  logic [NV_W-1:0]  row4, col4, nlast;
  logic             is_last_entry;

  spa_ctl_t         ctl   [MAX_VARS];
  spa_mv_t          mv    [MAX_VARS];
  spa_mv_t          nb    [MAX_VARS];
  logic [PI_W-1:0]  rdacc [MAX_VARS];

  spa_div_st_t      div_st;
  logic [PI_W-1:0]  div_q;

  assign accept    = in_valid & in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign row4      = {1'b0, in_data.row_index};
  assign col4      = {1'b0, in_data.col_index};
  assign nlast     = nv_r - 1'b1;
  assign is_last_entry = ({1'b0, ei_r} == nlast) && ({1'b0, ej_r} == nlast);
  assign acc_clr   = (state_r == S_OUT) && out_ready && is_last_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= NV_W'(MAX_VARS);
    end else if (cfg_we) begin
      if (cfg_data == '0) begin
        nv_r <= NV_W'(1);
      end else if (cfg_data > NV_W'(MAX_VARS)) begin
        nv_r <= NV_W'(MAX_VARS);
      end else begin
        nv_r <= cfg_data;
      end
    end
  end

  generate
    for (genvar k = 0; k < MAX_VARS; k++) begin : g_cell
      always_comb begin
        ctl[k].active   = (NV_W'(k) < nv_r);
        ctl[k].mean_we  = accept && (in_data.operation == OP_LOAD_MEAN) &&
                          (row4 == NV_W'(k));
        ctl[k].cov_we   = accept && (in_data.operation == OP_LOAD_COV) &&
                          (row4 == NV_W'(k)) && (col4 < NV_W'(MAX_VARS));
        ctl[k].dev_we   = accept && (in_data.operation == OP_SAMPLE) &&
                          (row4 == NV_W'(k)) && (NV_W'(k) < nv_r);
        ctl[k].mv_load  = (state_r == S_LOAD);
        ctl[k].mv_shift = (state_r == S_SWEEP);
        ctl[k].clr      = acc_clr;
        ctl[k].col      = in_data.col_index;
        ctl[k].rd_col   = ej_r;
        ctl[k].value    = in_data.value;
      end

      // ring: the last active cell takes from cell zero
      if (k == MAX_VARS - 1) begin : g_wrap
        assign nb[k] = mv[0];
      end else begin : g_next
        assign nb[k] = (NV_W'(k + 1) == nv_r) ? mv[0] : mv[k+1];
      end

      spa_cell #(.MAX_VARS(MAX_VARS), .CELL_IDX(k)) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl[k]),
        .nb_in  (nb[k]),
        .mv_out (mv[k]),
        .rd_acc (rdacc[k])
      );
    end
  endgenerate

  spa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_DSTART),
    .dividend (rdacc[ei_r[AW-1:0]]),
    .divisor  (cnt_r),
    .status   (div_st),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_data.operation == OP_SAMPLE) && (row4 == nlast)) begin
          state_nxt = S_LOAD;
        end else if (accept && (in_data.operation == OP_FINISH)) begin
          state_nxt = S_DSTART;
        end
      end
      S_LOAD:   state_nxt = S_SWEEP;
      S_SWEEP:  if (sc_r == nlast) state_nxt = S_DRAIN;
      S_DRAIN:  if (dc_r == 3'd4) state_nxt = S_IDLE;
      S_DSTART: state_nxt = S_DWAIT;
      S_DWAIT:  if (div_st.done) state_nxt = S_OUT;
      S_OUT: begin
        if (out_ready) begin
          state_nxt = is_last_entry ? S_IDLE : S_DSTART;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sc_r        <= '0;
      dc_r        <= '0;
      ei_r        <= '0;
      ej_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          ei_r <= '0;
          ej_r <= '0;
        end
        S_LOAD:  sc_r <= '0;
        S_SWEEP: begin
          sc_r <= sc_r + 1'b1;
          dc_r <= '0;
        end
        S_DRAIN: begin
          dc_r <= dc_r + 1'b1;
          if (dc_r == 3'd4 && cnt_r != COUNT_MAX) begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DWAIT: if (div_st.done) out_valid_r <= 1'b1;
        S_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (is_last_entry) begin
              cnt_r <= '0;
            end else if ({1'b0, ej_r} == nlast) begin
              ej_r <= '0;
              ei_r <= ei_r + 1'b1;
            end else begin
              ej_r <= ej_r + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DWAIT && div_st.done) begin
      out_r.out_row    <= ei_r;
      out_r.out_col    <= ej_r;
      out_r.pi_value   <= div_q;
      out_r.last_entry <= is_last_entry;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP) |-> (sc_r < nv_r))
    else $error("ring rotation ran past the active cells");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last_entry) |=> (cnt_r == '0 && in_ready))
    else $error("sample count not cleared after the last entry");

  a_active_range: assert property (@(posedge clk) disable iff (!rst_n)
    (nv_r != '0) && (nv_r <= NV_W'(MAX_VARS)))
    else $error("active variable count out of range");

  a_div_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !div_st.busy)
    else $error("divider busy while a result is shown");

endmodule

/* verif/shrinkage_pi_checker.sv */
`timescale 1ns / 1ps
module shrinkage_pi_checker import spa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  spa_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  spa_out_t out_data,
  input  logic     cfg_we,
  input  logic [NV_W-1:0] cfg_data,
  output int       fail_count,
  output int       pending_entries
);

  logic signed [31:0] means [8];
  logic signed [31:0] covs [64];
  logic signed [32:0] devs [8];
  logic [62:0] acc [64];
  logic [31:0] n_samples;
  int nvars;
  spa_out_t pi_expected [$];

  assign pending_entries = pi_expected.size();

  // saturated Q47.16 square of (di*dj - s), with di*dj and s in Q16.16
  function automatic logic [62:0] pi_term(logic signed [32:0] di, logic signed [32:0] dj,
                                          logic signed [31:0] s);
    logic signed [65:0] prod;
    logic signed [65:0] q;
    logic signed [65:0] e;
    logic [131:0] sq;
    prod = $signed(di) * $signed(dj);
    q = prod >>> 16;
    e = q - s;
    if (e < 0) e = -e;
    sq = $unsigned(e) * $unsigned(e);
    sq = sq >> 16;
    if (sq[131:63] != 0) return PI_MAX;
    return sq[62:0];
  endfunction

  task automatic close_column();
    logic [63:0] t;
    for (int i = 0; i < nvars; i++)
      for (int j = 0; j < nvars; j++) begin
        t = {1'b0, acc[i*8+j]} + {1'b0, pi_term(devs[i], devs[j], covs[i*8+j])};
        acc[i*8+j] = t[63] ? PI_MAX : t[62:0];
      end
    if (n_samples != COUNT_MAX) n_samples++;
  endtask

  task automatic emit_matrix();
    spa_out_t r;
    for (int i = 0; i < nvars; i++)
      for (int j = 0; j < nvars; j++) begin
        r.out_row = i[2:0];
        r.out_col = j[2:0];
        r.pi_value = (n_samples == 0) ? '0 : acc[i*8+j] / n_samples;
        r.last_entry = (i == nvars-1 && j == nvars-1);
        pi_expected.push_back(r);
      end
    foreach (acc[k]) acc[k] = '0;
    n_samples = 0;
  endtask

  always @(posedge clk) begin
    spa_out_t e;
    if (!rst_n) begin
      foreach (acc[k]) acc[k] = '0;
      n_samples = 0;
      nvars = 8;
      fail_count = 0;
    end else begin
      if (cfg_we)
        nvars = (cfg_data == 0) ? 1 : (cfg_data > 8) ? 8 : int'(cfg_data);
      if (in_valid && in_ready) begin
        case (in_data.operation)
          OP_LOAD_MEAN: means[in_data.row_index] = in_data.value;
          OP_LOAD_COV:  covs[{in_data.row_index, in_data.col_index}] = in_data.value;
          OP_SAMPLE: begin
            if (in_data.row_index < nvars) begin
              devs[in_data.row_index] = $signed(in_data.value) - $signed(means[in_data.row_index]);
              if (in_data.row_index == nvars-1) close_column();
            end
          end
          OP_FINISH: emit_matrix();
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pi_expected.size() == 0) begin
          $display("%0t: unexpected entry %p", $time, out_data);
          fail_count++;
        end else begin
          e = pi_expected.pop_front();
          if (out_data !== e) begin
            $display("%0t: mismatch expected row %0d col %0d pi %0h last %0b, got row %0d col %0d pi %0h last %0b",
                     $time, e.out_row, e.out_col, e.pi_value, e.last_entry,
                     out_data.out_row, out_data.out_col, out_data.pi_value, out_data.last_entry);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

/* verif/shrinkage_pi_accumulator_tb.sv */
`timescale 1ns / 1ps
module shrinkage_pi_accumulator_tb;
  import spa_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  spa_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  spa_out_t out_data;
  logic cfg_we = 0;
  logic [NV_W-1:0] cfg_data = '0;
  int fail_count;
  int pending_entries;
  int idle_cycles = 0;
  bit hold_output = 0;
  int nv = 8;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  shrinkage_pi_accumulator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  shrinkage_pi_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_entries(pending_entries)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // receiver: random stalls, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_output) out_ready <= 0;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // returns at the falling edge after acceptance with valid still high: the next send
  // either lowers it for a gap or puts new data out in that same step, and drain lowers it
  task automatic send(logic [1:0] op, int row, int col, logic [31:0] val);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_data <= '{operation: op, row_index: row[2:0], col_index: col[2:0], value: val};
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_entries != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic set_vars(logic [3:0] v);
    drain();
    cfg_data <= v;
    cfg_we <= 1;
    @(negedge clk);
    cfg_we <= 0;
    nv = (v == 0) ? 1 : (v > 8) ? 8 : v;
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h3ffff) - 32'h20000;
      default: return $urandom;
    endcase
  endfunction

  // load every mean and covariance entry so nothing is read unwritten
  task automatic load_stats();
    for (int i = 0; i < 8; i++) send(OP_LOAD_MEAN, i, $urandom_range(0, 7), rand_val());
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 8; j++) send(OP_LOAD_COV, i, j, rand_val());
  endtask

  task automatic send_column();
    for (int i = 0; i < nv; i++) send(OP_SAMPLE, i, $urandom_range(0, 7), rand_val());
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: extremes, zero-sample finish, ignored rows
    load_stats();
    send(OP_FINISH, 0, 0, 0);
    send(OP_SAMPLE, 0, 7, 32'h7fffffff);
    for (int i = 1; i < 8; i++) send(OP_SAMPLE, i, 0, 32'h80000000);
    send_column();
    send(OP_FINISH, 7, 7, 32'hffffffff);
    set_vars(0);
    send(OP_SAMPLE, 5, 0, 32'h1234);
    send(OP_SAMPLE, 0, 0, 32'h10000);
    send(OP_FINISH, 0, 0, 0);
    set_vars(15);
    set_vars(3);
    send(OP_SAMPLE, 6, 0, 0);
    send_column();
    send(OP_SAMPLE, 2, 0, 32'h55555555);
    send(OP_FINISH, 0, 0, 0);

    // random phases
    for (int ph = 0; ph < 6; ph++) begin
      set_vars($urandom_range(0, 15));
      if (ph == 3) begin
        hold_output = 1;
        fork
          begin
            repeat (600) @(negedge clk);
            hold_output = 0;
          end
        join_none
      end
      repeat ($urandom_range(3, 6)) begin
        if ($urandom_range(0, 3) == 0) send(OP_LOAD_MEAN, $urandom_range(0, 7), 0, rand_val());
        if ($urandom_range(0, 3) == 0)
          send(OP_LOAD_COV, $urandom_range(0, 7), $urandom_range(0, 7), rand_val());
        if ($urandom_range(0, 5) == 0) send(OP_SAMPLE, $urandom_range(0, 7), 0, rand_val());
        else send_column();
      end
      send(OP_FINISH, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
      if (ph == 5) drain();
      send(OP_FINISH, 0, 0, 0);
    end

    drain();
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
